// ----- src/vnorm_pkg.sv -----
// ----------------------------------------------------------------------------
// vnorm_pkg: shared types and constants of the 3D vector normalizer
// Request and response structs, field widths and pipeline depth figures.
// ----------------------------------------------------------------------------
package vnorm_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int FRAC_BITS = 14;
	localparam int OUT_WIDTH = FRAC_BITS + 2;
	// quotient magnitude bits, sum of squares bits, residual bits
	localparam int QW  = FRAC_BITS + 1;
	localparam int SW  = 2 * IN_WIDTH;
	localparam int TW  = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;
	// one stage per quotient bit, plus square, sum and output stages
	localparam int NIT = FRAC_BITS + 1;
	localparam int NST = NIT + 3;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] x_in;
		logic signed [IN_WIDTH-1:0] y_in;
		logic signed [IN_WIDTH-1:0] z_in;
	} req_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] x_unit;
		logic signed [OUT_WIDTH-1:0] y_unit;
		logic signed [OUT_WIDTH-1:0] z_unit;
		logic                        zero_error;
	} rsp_t;

endpackage

// ----- src/vector3_normalizer_core.sv -----
// ----------------------------------------------------------------------------
// vector3_normalizer_core: unit vector of a signed integer 3-vector
// Gives trunc(c * 2^14 / sqrt(x^2+y^2+z^2)) for each component, exact.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while req_stall is low; each response passes
// the square, sum, 15 quotient-bit stages and output register. The depth is
// set by the one-bit-per-stage search for the 15-bit quotient magnitude in
// each of three parallel lanes. Each stage has its own valid bit, so bubbles
// close up under stall and a new request is taken while a response waits if
// any stage is empty. A zero vector returns zero_error with zero components.
module vector3_normalizer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  vnorm_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output vnorm_pkg::rsp_t   rsp
);

	localparam int NST = vnorm_pkg::NST;
	localparam int NIT = vnorm_pkg::NIT;
	localparam int SW  = vnorm_pkg::SW;
	localparam int QW  = vnorm_pkg::QW;

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;
	logic [SW-1:0]  sq_x, sq_y, sq_z;
	logic [SW-1:0]  sum_s2;
	logic           zero_s2;
	logic           zero_it_sx [NIT];
	logic [QW-1:0]  q_x, q_y, q_z;
	logic [2:0]     neg;

	// advance a stage when it is empty or the next one advances
	always_comb begin
		en[NST-1] = ~v_q[NST-1] | ~rsp_stall;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = ~v_q[k] | en[k+1];
		end
	end

	assign req_stall = ~en[0];
	assign rsp_valid = v_q[NST-1];

	// move valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= req_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	vnorm_lane u_lane_x (
		.clk(clk), .en(en[NST-2:0]), .comp(req.x_in), .sum_sq(sum_s2),
		.square(sq_x), .q(q_x), .neg(neg[0])
	);
	vnorm_lane u_lane_y (
		.clk(clk), .en(en[NST-2:0]), .comp(req.y_in), .sum_sq(sum_s2),
		.square(sq_y), .q(q_y), .neg(neg[1])
	);
	vnorm_lane u_lane_z (
		.clk(clk), .en(en[NST-2:0]), .comp(req.z_in), .sum_sq(sum_s2),
		.square(sq_z), .q(q_z), .neg(neg[2])
	);

	// sum the squares and flag the zero vector
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sum_s2  <= sq_x + sq_y + sq_z;
			zero_s2 <= ((sq_x | sq_y | sq_z) == '0);
		end
	end

	// carry the zero flag beside the quotient stages
	for (genvar j = 0; j < NIT; j++) begin : g_zero
		always_ff @(posedge clk) begin
			if (en[2+j]) begin
				zero_it_sx[j] <= (j == 0) ? zero_s2 : zero_it_sx[(j == 0) ? 0 : j-1];
			end
		end
	end

	vnorm_merge u_merge (
		.clk(clk), .load(en[NST-1]), .q_x(q_x), .q_y(q_y), .q_z(q_z),
		.neg(neg), .zero(zero_it_sx[NIT-1]), .rsp(rsp)
	);

endmodule

// ----- src/vnorm_lane.sv -----
// ----------------------------------------------------------------------------
// vnorm_lane: one component lane of the normalizer
// Squares the component magnitude, then finds the largest q with
// q^2 * S <= c^2 * 2^(2F), one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module vnorm_lane (
	input  logic                                    clk,
	input  logic [vnorm_pkg::NST-2:0]               en,
	input  logic signed [vnorm_pkg::IN_WIDTH-1:0]   comp,
	input  logic [vnorm_pkg::SW-1:0]                sum_sq,
	output logic [vnorm_pkg::SW-1:0]                square,
	output logic [vnorm_pkg::QW-1:0]                q,
	output logic                                    neg
);

	localparam int MW  = vnorm_pkg::IN_WIDTH;
	localparam int SW  = vnorm_pkg::SW;
	localparam int TW  = vnorm_pkg::TW;
	localparam int QW  = vnorm_pkg::QW;
	localparam int NIT = vnorm_pkg::NIT;
	localparam int F   = vnorm_pkg::FRAC_BITS;

	logic [MW-1:0] mag_c;
	logic [SW-1:0] square_s1;
	logic          neg_s1;
	logic [SW-1:0] square_s2;
	logic          neg_s2;

	logic [TW-1:0] it_d_sx [NIT];
	logic [TW-1:0] it_p_sx [NIT];
	logic [QW-1:0] it_q_sx [NIT];
	logic [SW-1:0] it_s_sx [NIT];
	logic          it_n_sx [NIT];

	// take the magnitude unsigned so the most negative value stays exact
	assign mag_c = comp[MW-1] ? MW'(-comp) : MW'(comp);

	// square the magnitude
	always_ff @(posedge clk) begin
		if (en[0]) begin
			square_s1 <= SW'(mag_c) * SW'(mag_c);
			neg_s1    <= comp[MW-1];
		end
	end

	// hold the square while the sum is formed
	always_ff @(posedge clk) begin
		if (en[1]) begin
			square_s2 <= square_s1;
			neg_s2    <= neg_s1;
		end
	end

	// restoring search, one quotient bit per stage, shifts and adds only
	for (genvar j = 0; j < NIT; j++) begin : g_it
		localparam int B = F - j;
		logic [TW-1:0] d_in, p_in, term;
		logic [QW-1:0] q_in;
		logic [SW-1:0] s_in;
		logic          n_in, fit;

		if (j == 0) begin : g_first
			assign d_in = TW'(square_s2) << (2 * F);
			assign p_in = '0;
			assign q_in = '0;
			assign s_in = sum_sq;
			assign n_in = neg_s2;
		end else begin : g_next
			assign d_in = it_d_sx[j-1];
			assign p_in = it_p_sx[j-1];
			assign q_in = it_q_sx[j-1];
			assign s_in = it_s_sx[j-1];
			assign n_in = it_n_sx[j-1];
		end

		// cost of setting bit B: (2*q*2^B + 2^2B) * S
		assign term = (p_in << (B + 1)) + (TW'(s_in) << (2 * B));
		assign fit  = (term <= d_in);

		always_ff @(posedge clk) begin
			if (en[2+j]) begin
				it_d_sx[j] <= fit ? d_in - term : d_in;
				it_p_sx[j] <= fit ? p_in + (TW'(s_in) << B) : p_in;
				it_q_sx[j] <= fit ? (q_in | (QW'(1) << B)) : q_in;
				it_s_sx[j] <= s_in;
				it_n_sx[j] <= n_in;
			end
		end
	end

	assign square = square_s1;
	assign q      = it_q_sx[NIT-1];
	assign neg    = it_n_sx[NIT-1];

endmodule

// ----- src/vnorm_merge.sv -----
// ----------------------------------------------------------------------------
// vnorm_merge: merge of the three lanes into one response
// Applies the component signs, forces zeros on a zero vector, registers.
// ----------------------------------------------------------------------------
module vnorm_merge (
	input  logic                         clk,
	input  logic                         load,
	input  logic [vnorm_pkg::QW-1:0]     q_x,
	input  logic [vnorm_pkg::QW-1:0]     q_y,
	input  logic [vnorm_pkg::QW-1:0]     q_z,
	input  logic [2:0]                   neg,
	input  logic                         zero,
	output vnorm_pkg::rsp_t              rsp
);

	localparam int OW = vnorm_pkg::OUT_WIDTH;

	vnorm_pkg::rsp_t rsp_q;

	function automatic logic [OW-1:0] signed_unit(input logic [vnorm_pkg::QW-1:0] mag,
			input logic n, input logic z);
		logic [OW-1:0] ext;
		ext = OW'(mag);
		if (z) return '0;
		return n ? OW'(-ext) : ext;
	endfunction

	// load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.x_unit     <= signed_unit(q_x, neg[0], zero);
			rsp_q.y_unit     <= signed_unit(q_y, neg[1], zero);
			rsp_q.z_unit     <= signed_unit(q_z, neg[2], zero);
			rsp_q.zero_error <= zero;
		end
	end

	assign rsp = rsp_q;

endmodule
